// File: src/opm_pkg.sv
package opm_pkg;

    localparam int FRAC_BITS = 16;
    localparam int Q_W       = 32;
    localparam int NUM_W     = 65;
    localparam int DEN_W     = 33;
    localparam int DIV_STEPS = 64;
    localparam int DIV_LAT   = DIV_STEPS + 2;
    localparam int PIPE_LAT  = 2 * DIV_LAT + 5;
    localparam int IQ_DEPTH  = 4;
    localparam int OQ_DEPTH  = 2;
    localparam int CFG_AW    = 5;

    localparam logic signed [Q_W-1:0]   Q_MAX  = 32'sh7fffffff;
    localparam logic signed [Q_W-1:0]   Q_MIN  = 32'sh80000000;
    localparam logic signed [NUM_W-1:0] SAT_HI = 65'sd2147483647;
    localparam logic signed [NUM_W-1:0] SAT_LO = -65'sd2147483648;

    typedef enum logic [2:0] {
        REG_LEFT   = 3'd0,
        REG_RIGHT  = 3'd1,
        REG_BOTTOM = 3'd2,
        REG_TOP    = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5,
        REG_ASPECT = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0] left;
        logic signed [Q_W-1:0] right;
        logic signed [Q_W-1:0] bottom;
        logic signed [Q_W-1:0] top;
        logic signed [Q_W-1:0] near_plane;
        logic signed [Q_W-1:0] far_plane;
        logic signed [Q_W-1:0] aspect;
    } t_cfg;

    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } t_eye;

    typedef struct packed {
        logic signed [Q_W-1:0] e0;
        logic signed [Q_W-1:0] e2;
        logic signed [Q_W-1:0] e5;
        logic signed [Q_W-1:0] e6;
        logic signed [Q_W-1:0] e10;
        logic signed [Q_W-1:0] e11;
        logic                  fault;
    } t_result;

    // Clamp a wide signed value to the 32-bit range.
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [NUM_W-1:0] v);
        logic signed [Q_W-1:0] r;
        if (v > SAT_HI) begin
            r = Q_MAX;
        end else if (v < SAT_LO) begin
            r = Q_MIN;
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/opm_front.sv
module opm_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  opm_pkg::t_eye i_eye,
    input  logic          i_pop,
    output logic          o_nempty,
    output opm_pkg::t_eye o_eye
);
    import opm_pkg::*;

    localparam int AW = $clog2(IQ_DEPTH);
    localparam int CW = $clog2(IQ_DEPTH + 1);

    t_eye            r_mem [IQ_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_cnt;
    logic            s_wr;
    logic            s_rd;

    assign o_full   = (r_cnt == CW'(IQ_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_eye    = r_mem[r_rd_ptr];
    assign s_wr     = i_push & ~o_full;
    assign s_rd     = i_pop & o_nempty;

    always_ff @(posedge i_clk) begin
        if (s_wr) begin
            r_mem[r_wr_ptr] <= i_eye;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (s_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (s_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({s_wr, s_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: src/opm_div.sv
module opm_div (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [opm_pkg::NUM_W-1:0]     i_num,
    input  logic signed [opm_pkg::DEN_W-1:0]     i_den,
    input  logic                                 i_fault,
    output logic signed [opm_pkg::Q_W-1:0]       o_quot,
    output logic                                 o_fault
);
    import opm_pkg::*;

    typedef struct packed {
        logic [DIV_STEPS-1:0] work;
        logic [DEN_W-1:0]     rem;
        logic [DEN_W-1:0]     dmag;
        logic                 neg;
        logic                 nsign;
        logic                 nzero;
        logic                 dzero;
        logic                 fault;
    } t_dstage;

    t_dstage                 r_st [DIV_STEPS+1];
    logic [NUM_W-1:0]        s_nabs;
    logic [DEN_W-1:0]        s_dabs;
    logic signed [Q_W-1:0]   r_quot;
    logic                    r_fault;
    logic signed [Q_W-1:0]   s_quot;
    logic [DIV_STEPS-1:0]    s_q;

    assign s_nabs = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign s_dabs = i_den[DEN_W-1] ? DEN_W'(-i_den) : DEN_W'(i_den);

    // Load magnitudes and signs.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st[0].work  <= s_nabs[DIV_STEPS-1:0];
            r_st[0].rem   <= '0;
            r_st[0].dmag  <= s_dabs;
            r_st[0].neg   <= i_num[NUM_W-1] ^ i_den[DEN_W-1];
            r_st[0].nsign <= i_num[NUM_W-1];
            r_st[0].nzero <= (i_num == '0);
            r_st[0].dzero <= (i_den == '0);
            r_st[0].fault <= i_fault;
        end
    end

    // One quotient bit per stage, restoring.
    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
        logic [DEN_W:0] s_trial;
        logic           s_ge;
        t_dstage        s_nxt;
        assign s_trial = {r_st[g].rem, r_st[g].work[DIV_STEPS-1]};
        assign s_ge    = (s_trial >= {1'b0, r_st[g].dmag});

        always_comb begin
            s_nxt      = r_st[g];
            s_nxt.work = {r_st[g].work[DIV_STEPS-2:0], s_ge};
            s_nxt.rem  = s_ge ? DEN_W'(s_trial - {1'b0, r_st[g].dmag})
                              : DEN_W'(s_trial);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[g+1] <= s_nxt;
            end
        end
    end

    assign s_q = r_st[DIV_STEPS].work;

    always_comb begin
        priority if (r_st[DIV_STEPS].dzero) begin
            if (r_st[DIV_STEPS].nzero) begin
                s_quot = '0;
            end else if (r_st[DIV_STEPS].nsign) begin
                s_quot = Q_MIN;
            end else begin
                s_quot = Q_MAX;
            end
        end else if (r_st[DIV_STEPS].neg) begin
            s_quot = (s_q > DIV_STEPS'(64'h8000_0000)) ? Q_MIN
                                                       : Q_W'(DIV_STEPS'(0) - s_q);
        end else begin
            s_quot = (s_q > DIV_STEPS'(64'h7fff_ffff)) ? Q_MAX : s_q[Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quot  <= s_quot;
            r_fault <= r_st[DIV_STEPS].fault | r_st[DIV_STEPS].dzero;
        end
    end

    assign o_quot  = r_quot;
    assign o_fault = r_fault;

endmodule

// File: src/opm_back.sv
module opm_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  opm_pkg::t_cfg    i_cfg,
    input  logic             i_q_nempty,
    input  opm_pkg::t_eye    i_q_eye,
    output logic             o_q_pop,
    input  logic             i_pop,
    output logic             o_empty,
    output opm_pkg::t_result o_result
);
    import opm_pkg::*;

    localparam int OAW = $clog2(OQ_DEPTH);
    localparam int OCW = $clog2(OQ_DEPTH + 1);

    logic                    s_en;
    logic [PIPE_LAT-1:0]     r_vld;

    logic signed [63:0]      r_a_pl, r_a_pr;
    logic signed [Q_W-1:0]   r_a_db, r_a_dt, r_a_ex, r_a_ez;
    logic signed [Q_W-1:0]   s_la, s_ra;
    logic signed [Q_W-1:0]   r_b_dl, r_b_dr, r_b_db, r_b_dt, r_b_ez;
    logic signed [63:0]      r_c_nl, r_c_nr, r_c_nb, r_c_nt;
    logic signed [Q_W-1:0]   r_c_ez;

    logic signed [Q_W-1:0]   w_l, w_r, w_b, w_t;
    logic [3:0]              w_ef;

    logic signed [Q_W-1:0]   r_e1_l, r_e1_r, r_e1_b, r_e1_t;
    logic signed [63:0]      r_e1_fn;
    logic                    r_e1_fault;

    logic signed [NUM_W-1:0] r_e2_n0, r_e2_n2, r_e2_n6, r_e2_n10, r_e2_n11;
    logic signed [DEN_W-1:0] r_e2_d_rl, r_e2_d_tb, r_e2_d_fn;
    logic                    r_e2_fault;

    logic [5:0]              w_of;
    t_result                 s_res;

    t_result                 r_oq [OQ_DEPTH];
    logic [OAW-1:0]          r_oq_wr;
    logic [OAW-1:0]          r_oq_rd;
    logic [OCW-1:0]          r_oq_cnt;
    logic                    s_oq_push;
    logic                    s_oq_pop;

    // The whole pipeline advances together while the output queue has room.
    assign s_en      = (r_oq_cnt != OCW'(OQ_DEPTH));
    assign o_q_pop   = s_en & i_q_nempty;
    assign s_oq_push = s_en & r_vld[PIPE_LAT-1];
    assign s_oq_pop  = i_pop & ~o_empty;
    assign o_empty   = (r_oq_cnt == '0);
    assign o_result  = r_oq[r_oq_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (s_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], o_q_pop};
        end
    end

    assign s_la = sat32(NUM_W'(r_a_pl >>> FRAC_BITS));
    assign s_ra = sat32(NUM_W'(r_a_pr >>> FRAC_BITS));

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_a_pl <= i_cfg.left * i_cfg.aspect;
            r_a_pr <= i_cfg.right * i_cfg.aspect;
            r_a_db <= sat32(NUM_W'(i_cfg.bottom) - NUM_W'(i_q_eye.y));
            r_a_dt <= sat32(NUM_W'(i_cfg.top) - NUM_W'(i_q_eye.y));
            r_a_ex <= i_q_eye.x;
            r_a_ez <= i_q_eye.z;

            r_b_dl <= sat32(NUM_W'(s_la) - NUM_W'(r_a_ex));
            r_b_dr <= sat32(NUM_W'(s_ra) - NUM_W'(r_a_ex));
            r_b_db <= r_a_db;
            r_b_dt <= r_a_dt;
            r_b_ez <= r_a_ez;

            r_c_nl <= r_b_dl * i_cfg.near_plane;
            r_c_nr <= r_b_dr * i_cfg.near_plane;
            r_c_nb <= r_b_db * i_cfg.near_plane;
            r_c_nt <= r_b_dt * i_cfg.near_plane;
            r_c_ez <= r_b_ez;
        end
    end

    opm_div u_div_l (.i_clk, .i_en(s_en), .i_num(NUM_W'(r_c_nl)), .i_den(DEN_W'(r_c_ez)),
                     .i_fault(1'b0), .o_quot(w_l), .o_fault(w_ef[0]));
    opm_div u_div_r (.i_clk, .i_en(s_en), .i_num(NUM_W'(r_c_nr)), .i_den(DEN_W'(r_c_ez)),
                     .i_fault(1'b0), .o_quot(w_r), .o_fault(w_ef[1]));
    opm_div u_div_b (.i_clk, .i_en(s_en), .i_num(NUM_W'(r_c_nb)), .i_den(DEN_W'(r_c_ez)),
                     .i_fault(1'b0), .o_quot(w_b), .o_fault(w_ef[2]));
    opm_div u_div_t (.i_clk, .i_en(s_en), .i_num(NUM_W'(r_c_nt)), .i_den(DEN_W'(r_c_ez)),
                     .i_fault(1'b0), .o_quot(w_t), .o_fault(w_ef[3]));

    always_ff @(posedge i_clk) begin
        if (s_en) begin
            r_e1_l     <= w_l;
            r_e1_r     <= w_r;
            r_e1_b     <= w_b;
            r_e1_t     <= w_t;
            r_e1_fn    <= i_cfg.far_plane * i_cfg.near_plane;
            r_e1_fault <= |w_ef;

            r_e2_n0    <= NUM_W'(i_cfg.near_plane) <<< (FRAC_BITS + 1);
            r_e2_n2    <= (NUM_W'(r_e1_r) + NUM_W'(r_e1_l)) <<< FRAC_BITS;
            r_e2_n6    <= (NUM_W'(r_e1_t) + NUM_W'(r_e1_b)) <<< FRAC_BITS;
            r_e2_n10   <= -((NUM_W'(i_cfg.far_plane) + NUM_W'(i_cfg.near_plane))
                            <<< FRAC_BITS);
            r_e2_n11   <= -(NUM_W'(r_e1_fn) <<< 1);
            r_e2_d_rl  <= DEN_W'(r_e1_r) - DEN_W'(r_e1_l);
            r_e2_d_tb  <= DEN_W'(r_e1_t) - DEN_W'(r_e1_b);
            r_e2_d_fn  <= DEN_W'(i_cfg.far_plane) - DEN_W'(i_cfg.near_plane);
            r_e2_fault <= r_e1_fault;
        end
    end

    opm_div u_div_e0  (.i_clk, .i_en(s_en), .i_num(r_e2_n0), .i_den(r_e2_d_rl),
                       .i_fault(r_e2_fault), .o_quot(s_res.e0), .o_fault(w_of[0]));
    opm_div u_div_e2  (.i_clk, .i_en(s_en), .i_num(r_e2_n2), .i_den(r_e2_d_rl),
                       .i_fault(1'b0), .o_quot(s_res.e2), .o_fault(w_of[1]));
    opm_div u_div_e5  (.i_clk, .i_en(s_en), .i_num(r_e2_n0), .i_den(r_e2_d_tb),
                       .i_fault(1'b0), .o_quot(s_res.e5), .o_fault(w_of[2]));
    opm_div u_div_e6  (.i_clk, .i_en(s_en), .i_num(r_e2_n6), .i_den(r_e2_d_tb),
                       .i_fault(1'b0), .o_quot(s_res.e6), .o_fault(w_of[3]));
    opm_div u_div_e10 (.i_clk, .i_en(s_en), .i_num(r_e2_n10), .i_den(r_e2_d_fn),
                       .i_fault(1'b0), .o_quot(s_res.e10), .o_fault(w_of[4]));
    opm_div u_div_e11 (.i_clk, .i_en(s_en), .i_num(r_e2_n11), .i_den(r_e2_d_fn),
                       .i_fault(1'b0), .o_quot(s_res.e11), .o_fault(w_of[5]));

    assign s_res.fault = |w_of;

    always_ff @(posedge i_clk) begin
        if (s_oq_push) begin
            r_oq[r_oq_wr] <= s_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (s_oq_push) begin
                r_oq_wr <= r_oq_wr + 1'b1;
            end
            if (s_oq_pop) begin
                r_oq_rd <= r_oq_rd + 1'b1;
            end
            unique case ({s_oq_push, s_oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 1'b1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 1'b1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

    a_oq_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oq_cnt <= OCW'(OQ_DEPTH))
        else $error("output queue overfilled");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_en |=> $stable(r_vld))
        else $error("pipeline moved while stalled");

    a_no_pull_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_oq_cnt < OCW'(OQ_DEPTH)))
        else $error("input queue read while output queue full");

endmodule

// File: src/off_axis_projection_matrix.sv
// Head-coupled off-axis projection: program the screen window through the APB port while the
// block is idle, then push one eye position (Q16.16) per word; each word yields one result word
// holding entries 0, 2, 5, 6, 10 and 11 of the projection matrix (entries 14 and 15 are the
// fixed -1 and 0) and a divide-fault flag. One word is taken per clock when the result side
// keeps up. The datapath is two banks of one-bit-per-stage pipelined dividers in series:
// the first projects the edges onto the near plane, the second forms the matrix entries.
// The input queue holds IQ_DEPTH words and the output queue OQ_DEPTH words; a full output
// queue freezes the whole datapath. A zero divisor sets the fault flag and saturates the
// entry, or gives zero when the numerator is also zero.
module off_axis_projection_matrix (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [opm_pkg::CFG_AW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic signed [opm_pkg::Q_W-1:0]    i_eye_x,
    input  logic signed [opm_pkg::Q_W-1:0]    i_eye_y,
    input  logic signed [opm_pkg::Q_W-1:0]    i_eye_z,
    output logic                              empty,
    input  logic                              pop,
    output logic signed [opm_pkg::Q_W-1:0]    o_entry_0,
    output logic signed [opm_pkg::Q_W-1:0]    o_entry_2,
    output logic signed [opm_pkg::Q_W-1:0]    o_entry_5,
    output logic signed [opm_pkg::Q_W-1:0]    o_entry_6,
    output logic signed [opm_pkg::Q_W-1:0]    o_entry_10,
    output logic signed [opm_pkg::Q_W-1:0]    o_entry_11,
    output logic                              o_divide_fault
);
    import opm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx s_idx;
    logic     s_cfg_wr;
    t_eye     s_eye_in;
    t_eye     w_q_eye;
    logic     w_q_nempty;
    logic     w_q_pop;
    t_result  w_res;

    // Registers sit on word addresses; drop the byte offset.
    assign s_idx    = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign s_cfg_wr = psel & penable & pwrite & pready;
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (s_cfg_wr) begin
            unique case (s_idx)
                REG_LEFT:   r_cfg.left       <= pwdata;
                REG_RIGHT:  r_cfg.right      <= pwdata;
                REG_BOTTOM: r_cfg.bottom     <= pwdata;
                REG_TOP:    r_cfg.top        <= pwdata;
                REG_NEAR:   r_cfg.near_plane <= pwdata;
                REG_FAR:    r_cfg.far_plane  <= pwdata;
                REG_ASPECT: r_cfg.aspect     <= pwdata;
                default:    r_cfg            <= r_cfg;
            endcase
        end
    end

    // Read back; the unused address returns zero.
    always_comb begin
        unique case (s_idx)
            REG_LEFT:   prdata = r_cfg.left;
            REG_RIGHT:  prdata = r_cfg.right;
            REG_BOTTOM: prdata = r_cfg.bottom;
            REG_TOP:    prdata = r_cfg.top;
            REG_NEAR:   prdata = r_cfg.near_plane;
            REG_FAR:    prdata = r_cfg.far_plane;
            REG_ASPECT: prdata = r_cfg.aspect;
            default:    prdata = '0;
        endcase
    end

    assign s_eye_in.x = i_eye_x;
    assign s_eye_in.y = i_eye_y;
    assign s_eye_in.z = i_eye_z;

    // Front: take words into the input queue.
    opm_front u_front (
        .i_clk,
        .i_rst_n,
        .i_push   (push),
        .o_full   (full),
        .i_eye    (s_eye_in),
        .i_pop    (w_q_pop),
        .o_nempty (w_q_nempty),
        .o_eye    (w_q_eye)
    );

    // Back: projection, matrix entries and the result queue.
    opm_back u_back (
        .i_clk,
        .i_rst_n,
        .i_cfg      (r_cfg),
        .i_q_nempty (w_q_nempty),
        .i_q_eye    (w_q_eye),
        .o_q_pop    (w_q_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (w_res)
    );

    assign o_entry_0      = w_res.e0;
    assign o_entry_2      = w_res.e2;
    assign o_entry_5      = w_res.e5;
    assign o_entry_6      = w_res.e6;
    assign o_entry_10     = w_res.e10;
    assign o_entry_11     = w_res.e11;
    assign o_divide_fault = w_res.fault;

endmodule
